// ===== src/tsg_pkg.sv =====
// ----------------------------------------------------------------------------
// tsg_pkg: shared definitions of the two-axis step event generator
// Command codes, register indexes, field widths and the per-axis control
// bundle passed from the command decoder to each axis unit.
// ----------------------------------------------------------------------------
package tsg_pkg;

   // Fixed widths of the transfer fields
   localparam int CMD_WIDTH       = 3;
   localparam int FIELD_WIDTH     = 24;
   localparam int POS_FIELD_WIDTH = 32;
   localparam int CSR_IDX_WIDTH   = 2;

   // Defaults for the top-level parameters
   localparam int POS_WIDTH_DEF   = 32;
   localparam int COUNT_WIDTH_DEF = 24;

   typedef enum logic [CMD_WIDTH-1:0] {
      CMD_LOAD     = 3'd0,
      CMD_TICK     = 3'd1,
      CMD_SET_BOTH = 3'd2,
      CMD_SET_ONE  = 3'd3,
      CMD_ENDSTOP  = 3'd4,
      CMD_ABORT    = 3'd5
   } tsg_cmd_type;

   typedef enum logic [CSR_IDX_WIDTH-1:0] {
      CSR_INVERT_X = 2'd0,
      CSR_INVERT_Y = 2'd1
   } tsg_csr_type;

   typedef enum logic {
      AXIS_X = 1'b0,
      AXIS_Y = 1'b1
   } tsg_axis_sel_type;

   // Per-axis controls, already qualified by the pipeline advance
   typedef struct packed {
      logic latch_dir;  // take a new direction
      logic load;       // start a move: preset counter, take step count
      logic tick;       // run one step event
      logic set_pos;    // overwrite the position
   } tsg_axis_ctl_type;

endpackage

// ===== src/tsg_axis.sv =====
// ----------------------------------------------------------------------------
// tsg_axis: one axis of the step event generator
// Error counter, step count, direction and wrapping position of one axis.
// Next-state values are exported so the result register sees them.
// ----------------------------------------------------------------------------
module tsg_axis #(
   parameter int POS_WIDTH   = tsg_pkg::POS_WIDTH_DEF,
   parameter int COUNT_WIDTH = tsg_pkg::COUNT_WIDTH_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  tsg_pkg::tsg_axis_ctl_type              ctl,
   input  logic [COUNT_WIDTH-1:0]                 steps,
   input  logic [COUNT_WIDTH-1:0]                 load_total,
   input  logic [COUNT_WIDTH-1:0]                 run_total,
   input  logic                                   neg,
   input  logic signed [tsg_pkg::POS_FIELD_WIDTH-1:0] pos_value,
   output logic                                   step,
   output logic                                   neg_next,
   output logic [POS_WIDTH-1:0]                   pos_cur,
   output logic [POS_WIDTH-1:0]                   pos_next
);
   import tsg_pkg::*;

   localparam int ACC_WIDTH = COUNT_WIDTH + 2;

   logic signed [ACC_WIDTH-1:0] accum_ff, accum_in;
   logic [COUNT_WIDTH-1:0]      steps_ff, steps_in;
   logic                        neg_ff, neg_in;
   logic [POS_WIDTH-1:0]        position_ff, position_in;

   logic signed [ACC_WIDTH-1:0] sum;
   logic [POS_WIDTH-1:0]        pos_set;

   assign sum     = accum_ff + $signed({2'b00, steps_ff});
   assign step    = ctl.tick && (sum > $signed(ACC_WIDTH'(0)));
   assign pos_set = POS_WIDTH'(pos_value);

   always_comb begin
      accum_in    = accum_ff;
      steps_in    = steps_ff;
      neg_in      = neg_ff;
      position_in = position_ff;
      if (ctl.latch_dir) begin
         neg_in = neg;
      end
      if (ctl.load) begin
         steps_in = (steps > load_total) ? load_total : steps;
         accum_in = -$signed({2'b00, (load_total >> 1)});
      end
      if (ctl.tick) begin
         accum_in = step ? (sum - $signed({2'b00, run_total})) : sum;
         if (step) begin
            position_in = neg_ff ? (position_ff - POS_WIDTH'(1))
                                 : (position_ff + POS_WIDTH'(1));
         end
      end
      if (ctl.set_pos) begin
         position_in = pos_set;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         accum_ff    <= '0;
         steps_ff    <= '0;
         neg_ff      <= 1'b0;
         position_ff <= '0;
      end else begin
         accum_ff    <= accum_in;
         steps_ff    <= steps_in;
         neg_ff      <= neg_in;
         position_ff <= position_in;
      end
   end

   assign neg_next = neg_in;
   assign pos_cur  = position_ff;
   assign pos_next = position_in;

endmodule

// ===== src/two_axis_step_event_generator_core.sv =====
// ----------------------------------------------------------------------------
// two_axis_step_event_generator_core: two-axis line step generator
// Path: an accepted command is held in the input register, moves into the
//   result register once that register is free, and transfers from there.
// Throughput: one command per cycle; the error counter add/compare/subtract
//   of each axis is the only work per step event. Stall only while a result
//   is held up.
// Reset: synchronous; clears counters, positions, capture, move and the
//   direction inversion registers. No clearing pass is needed.
// ----------------------------------------------------------------------------
module two_axis_step_event_generator_core #(
   parameter int POS_WIDTH   = tsg_pkg::POS_WIDTH_DEF,
   parameter int COUNT_WIDTH = tsg_pkg::COUNT_WIDTH_DEF
) (
   input  logic                                       clock,
   input  logic                                       reset,
   // command channel
   input  logic                                       req_valid,
   output logic                                       req_stall,
   input  logic [tsg_pkg::CMD_WIDTH-1:0]              req_command,
   input  logic [tsg_pkg::FIELD_WIDTH-1:0]            req_steps_x,
   input  logic [tsg_pkg::FIELD_WIDTH-1:0]            req_steps_y,
   input  logic [tsg_pkg::FIELD_WIDTH-1:0]            req_event_total,
   input  logic                                       req_dir_x_negative,
   input  logic                                       req_dir_y_negative,
   input  logic                                       req_axis_select,
   input  logic signed [tsg_pkg::POS_FIELD_WIDTH-1:0] req_position_a,
   input  logic signed [tsg_pkg::POS_FIELD_WIDTH-1:0] req_position_b,
   // result channel
   output logic                                       rsp_valid,
   input  logic                                       rsp_stall,
   output logic                                       rsp_step_x,
   output logic                                       rsp_step_y,
   output logic                                       rsp_dir_x_pin,
   output logic                                       rsp_dir_y_pin,
   output logic signed [tsg_pkg::POS_FIELD_WIDTH-1:0] rsp_pos_x,
   output logic signed [tsg_pkg::POS_FIELD_WIDTH-1:0] rsp_pos_y,
   output logic                                       rsp_move_active,
   output logic                                       rsp_move_done,
   output logic signed [tsg_pkg::POS_FIELD_WIDTH-1:0] rsp_trigger_pos,
   // register write channel
   input  logic                                       csr_valid,
   output logic                                       csr_ready,
   input  logic [tsg_pkg::CSR_IDX_WIDTH-1:0]          csr_index,
   input  logic                                       csr_data
);
   import tsg_pkg::*;

   // ---------------------------------------------------------------------
   // Direction inversion registers; the port never pushes back.
   // ---------------------------------------------------------------------
   logic invert_x_ff, invert_y_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         invert_x_ff <= 1'b0;
         invert_y_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         unique case (tsg_csr_type'(csr_index))
            CSR_INVERT_X: invert_x_ff <= csr_data;
            CSR_INVERT_Y: invert_y_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Handshake: the input register advances into the result register
   // whenever the result register is empty or being drained this cycle.
   // ---------------------------------------------------------------------
   logic s1_valid_ff, s1_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free, fire, req_accept;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign fire       = s1_valid_ff && out_free;
   assign req_stall  = s1_valid_ff && !out_free;
   assign req_accept = req_valid && !req_stall;

   assign s1_valid_in  = req_accept || (s1_valid_ff && !fire);
   assign rsp_valid_in = fire || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Input register: capture the command on each accepted transfer
   logic [CMD_WIDTH-1:0]               s1_cmd_ff;
   logic [COUNT_WIDTH-1:0]             s1_steps_x_ff, s1_steps_y_ff, s1_total_ff;
   logic                               s1_neg_x_ff, s1_neg_y_ff, s1_axis_ff;
   logic signed [POS_FIELD_WIDTH-1:0]  s1_pos_a_ff, s1_pos_b_ff;

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_cmd_ff     <= req_command;
         s1_steps_x_ff <= COUNT_WIDTH'(req_steps_x);
         s1_steps_y_ff <= COUNT_WIDTH'(req_steps_y);
         s1_total_ff   <= COUNT_WIDTH'(req_event_total);
         s1_neg_x_ff   <= req_dir_x_negative;
         s1_neg_y_ff   <= req_dir_y_negative;
         s1_axis_ff    <= req_axis_select;
         s1_pos_a_ff   <= req_position_a;
         s1_pos_b_ff   <= req_position_b;
      end
   end

   // ---------------------------------------------------------------------
   // Move state shared by both axes
   // ---------------------------------------------------------------------
   logic                   busy_ff, busy_in;
   logic [COUNT_WIDTH-1:0] events_ff, events_in, events_inc;
   logic [COUNT_WIDTH-1:0] total_ff, total_in;
   logic [POS_WIDTH-1:0]   captured_ff, captured_in;
   logic                   done;

   tsg_axis_ctl_type       ctl_x, ctl_y;
   logic                   step_x, step_y, neg_x_next, neg_y_next;
   logic [POS_WIDTH-1:0]   pos_x_cur, pos_y_cur, pos_x_next, pos_y_next;
   logic signed [POS_FIELD_WIDTH-1:0] pos_y_value;
   logic                   set_both;

   assign events_inc = events_ff + COUNT_WIDTH'(1);

   // Decode the command held in the input register; nothing moves unless
   // the item advances this cycle.
   always_comb begin
      ctl_x       = '0;
      ctl_y       = '0;
      busy_in     = busy_ff;
      events_in   = events_ff;
      total_in    = total_ff;
      captured_in = captured_ff;
      done        = 1'b0;
      set_both    = 1'b0;
      if (fire) begin
         case (tsg_cmd_type'(s1_cmd_ff))
            CMD_LOAD: begin
               // Ignore a load while a move runs; a zero total only
               // latches the directions.
               if (!busy_ff) begin
                  ctl_x.latch_dir = 1'b1;
                  ctl_y.latch_dir = 1'b1;
                  if (s1_total_ff != '0) begin
                     ctl_x.load = 1'b1;
                     ctl_y.load = 1'b1;
                     total_in   = s1_total_ff;
                     events_in  = '0;
                     busy_in    = 1'b1;
                  end
               end
            end
            CMD_TICK: begin
               if (busy_ff) begin
                  ctl_x.tick = 1'b1;
                  ctl_y.tick = 1'b1;
                  events_in  = events_inc;
                  if (events_inc >= total_ff) begin
                     busy_in = 1'b0;
                     done    = 1'b1;
                  end
               end
            end
            CMD_SET_BOTH: begin
               ctl_x.set_pos = 1'b1;
               ctl_y.set_pos = 1'b1;
               set_both      = 1'b1;
            end
            CMD_SET_ONE: begin
               if (tsg_axis_sel_type'(s1_axis_ff) == AXIS_Y) begin
                  ctl_y.set_pos = 1'b1;
               end else begin
                  ctl_x.set_pos = 1'b1;
               end
            end
            CMD_ENDSTOP: begin
               // Capture the hit axis and drop any running move
               captured_in = (tsg_axis_sel_type'(s1_axis_ff) == AXIS_Y)
                           ? pos_y_cur : pos_x_cur;
               busy_in     = 1'b0;
            end
            CMD_ABORT: begin
               busy_in = 1'b0;
            end
            default: ;
         endcase
      end
   end

   // Set-both takes Y from the second position field, set-one from the first
   assign pos_y_value = set_both ? s1_pos_b_ff : s1_pos_a_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b0;
         events_ff   <= '0;
         total_ff    <= '0;
         captured_ff <= '0;
      end else begin
         busy_ff     <= busy_in;
         events_ff   <= events_in;
         total_ff    <= total_in;
         captured_ff <= captured_in;
      end
   end

   // ---------------------------------------------------------------------
   // Axis units
   // ---------------------------------------------------------------------
   tsg_axis #(
      .POS_WIDTH   (POS_WIDTH),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_axis_x (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl_x),
      .steps      (s1_steps_x_ff),
      .load_total (s1_total_ff),
      .run_total  (total_ff),
      .neg        (s1_neg_x_ff),
      .pos_value  (s1_pos_a_ff),
      .step       (step_x),
      .neg_next   (neg_x_next),
      .pos_cur    (pos_x_cur),
      .pos_next   (pos_x_next)
   );

   tsg_axis #(
      .POS_WIDTH   (POS_WIDTH),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_axis_y (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl_y),
      .steps      (s1_steps_y_ff),
      .load_total (s1_total_ff),
      .run_total  (total_ff),
      .neg        (s1_neg_y_ff),
      .pos_value  (pos_y_value),
      .step       (step_y),
      .neg_next   (neg_y_next),
      .pos_cur    (pos_y_cur),
      .pos_next   (pos_y_next)
   );

   // ---------------------------------------------------------------------
   // Result register: load on advance, hold while stalled.
   // Direction pin follows the inversion bit when the axis runs negative
   // and its complement otherwise.
   // ---------------------------------------------------------------------
   logic                              rsp_step_x_ff, rsp_step_y_ff;
   logic                              rsp_dir_x_ff, rsp_dir_y_ff;
   logic signed [POS_FIELD_WIDTH-1:0] rsp_pos_x_ff, rsp_pos_y_ff, rsp_trig_ff;
   logic                              rsp_active_ff, rsp_done_ff;

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_step_x_ff <= step_x;
         rsp_step_y_ff <= step_y;
         rsp_dir_x_ff  <= ~(neg_x_next ^ invert_x_ff);
         rsp_dir_y_ff  <= ~(neg_y_next ^ invert_y_ff);
         rsp_pos_x_ff  <= POS_FIELD_WIDTH'(pos_x_next);
         rsp_pos_y_ff  <= POS_FIELD_WIDTH'(pos_y_next);
         rsp_active_ff <= busy_in;
         rsp_done_ff   <= done;
         rsp_trig_ff   <= POS_FIELD_WIDTH'(captured_in);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_step_x      = rsp_step_x_ff;
   assign rsp_step_y      = rsp_step_y_ff;
   assign rsp_dir_x_pin   = rsp_dir_x_ff;
   assign rsp_dir_y_pin   = rsp_dir_y_ff;
   assign rsp_pos_x       = rsp_pos_x_ff;
   assign rsp_pos_y       = rsp_pos_y_ff;
   assign rsp_move_active = rsp_active_ff;
   assign rsp_move_done   = rsp_done_ff;
   assign rsp_trigger_pos = rsp_trig_ff;

endmodule

// ===== src/tsg_checker.sv =====
// ----------------------------------------------------------------------------
// tsg_checker: port-level checks of the step event generator
// Watches the top-level ports only; attached to the top level by bind.
// ----------------------------------------------------------------------------
module tsg_checker (
   input logic                                       clock,
   input logic                                       reset,
   input logic                                       req_stall,
   input logic                                       rsp_valid,
   input logic                                       rsp_stall,
   input logic                                       rsp_step_x,
   input logic                                       rsp_step_y,
   input logic signed [tsg_pkg::POS_FIELD_WIDTH-1:0] rsp_pos_x,
   input logic signed [tsg_pkg::POS_FIELD_WIDTH-1:0] rsp_pos_y,
   input logic                                       rsp_move_active,
   input logic                                       rsp_move_done
);

   // Leave reset with an empty pipeline that takes commands at once
   ast_reset_empty: assert property (@(posedge clock)
      reset |=> (!rsp_valid && !req_stall))
      else $error("pipeline not empty after reset");

   // Push back on commands only while a result is held up
   ast_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("command stalled without a blocked result");

   // A completing tick leaves no move running
   ast_done_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_move_done) |-> !rsp_move_active)
      else $error("move reported done and active together");

   // Hold a stalled result
   ast_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_pos_x) && $stable(rsp_pos_y)
          && $stable(rsp_step_x) && $stable(rsp_step_y)))
      else $error("stalled result changed");

endmodule

bind two_axis_step_event_generator_core tsg_checker u_tsg_checker (
   .clock           (clock),
   .reset           (reset),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_step_x      (rsp_step_x),
   .rsp_step_y      (rsp_step_y),
   .rsp_pos_x       (rsp_pos_x),
   .rsp_pos_y       (rsp_pos_y),
   .rsp_move_active (rsp_move_active),
   .rsp_move_done   (rsp_move_done)
);
